@@ rtl/core/imr_pkg.sv @@
// imr_pkg: shared constants, codes and types of the image rotation block
// used by every module of rtl/core, no dependencies
package imr_pkg;

  localparam int MaxWidth    = 64;
  localparam int MaxHeight   = 64;
  localparam int MaxChannels = 4;
  localparam int PixelBits   = 16;
  localparam int FracBits    = 8;
  localparam int TrigShift   = 14;

  localparam int TrigW   = 16;
  localparam int SizeW   = 7;
  localparam int ChanW   = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;
  localparam int InPixW  = 16;

  localparam int ColW   = $clog2(MaxWidth);
  localparam int RowW   = $clog2(MaxHeight);
  localparam int PlaneW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  localparam int DeltaW = ((ColW > RowW) ? ColW : RowW) + FracBits + 2;
  localparam int ProdW  = DeltaW + TrigW;
  localparam int SumW   = ProdW + 1;
  localparam int CoordW = SumW - TrigShift + 1;
  localparam int IntW   = CoordW - FracBits;

  localparam int BankAddrW = PlaneW + (RowW - 1) + (ColW - 1);
  localparam int BankDepth = 1 << BankAddrW;

  localparam int WtW  = 2 * FracBits + 1;
  localparam int MulW = WtW + PixelBits;
  localparam int AccW = MulW + 2;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COS      = 3'd0,
    CFG_SIN      = 3'd1,
    CFG_WIDTH    = 3'd2,
    CFG_HEIGHT   = 3'd3,
    CFG_CHANNELS = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
  } imr_cfg_t;

  typedef struct packed {
    op_t                      op;
    logic                     bad;
    logic [PlaneW-1:0]        plane;
    logic [RowW-1:0]          row;
    logic [ColW-1:0]          col;
    logic [PixelBits-1:0]     pixel;
    logic signed [CoordW-1:0] nx;
    logic signed [CoordW-1:0] ny;
  } imr_item_t;

endpackage

@@ rtl/core/imr_if.sv @@
// imr_in_if and imr_out_if: valid/ready channels of the rotation block
// depends on imr_pkg
interface imr_in_if;
  logic                         valid;
  logic                         ready;
  imr_pkg::op_t                 opcode;
  logic [imr_pkg::PlaneW-1:0]   plane;
  logic [imr_pkg::RowW-1:0]     row;
  logic [imr_pkg::ColW-1:0]     col;
  logic [imr_pkg::InPixW-1:0]   pixel_in;

  modport source(output valid, opcode, plane, row, col, pixel_in, input ready);
  modport sink(input valid, opcode, plane, row, col, pixel_in, output ready);
endinterface

interface imr_out_if;
  logic                          valid;
  logic                          ready;
  logic [imr_pkg::PixelBits-1:0] pixel_out;
  logic                          coord_error;

  modport source(output valid, pixel_out, coord_error, input ready);
  modport sink(input valid, pixel_out, coord_error, output ready);
endinterface

@@ rtl/core/imr_front.sv @@
// imr_front: configuration registers, range check and source point pipeline
// depends on imr_pkg and imr_in_if
module imr_front (
  input  logic                    clk,
  input  logic                    rst,
  imr_in_if.sink                  req,
  input  logic                    cfg_we,
  input  logic [imr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [imr_pkg::CfgW-1:0]    cfg_data,
  input  logic                    q_full,
  output logic                    push,
  output imr_pkg::imr_item_t      push_item,
  output imr_pkg::imr_cfg_t       cfg
);
  import imr_pkg::*;

  logic signed [TrigW-1:0] cos_term;
  logic signed [TrigW-1:0] sin_term;
  logic [SizeW-1:0] image_width;
  logic [SizeW-1:0] image_height;
  logic [ChanW-1:0] channel_count;

  logic [SizeW-1:0] eff_w, eff_h;
  logic [ChanW-1:0] eff_c;
  logic [SizeW+FracBits-2:0] cxf, cyf;

  logic en;
  logic bad_in;
  logic signed [DeltaW-1:0] dx_in, dy_in;

  logic s1v, s2v, s3v;
  imr_item_t s1, s2, s3;
  logic signed [DeltaW-1:0] s1_dx, s1_dy;
  logic signed [ProdW-1:0] pcx, psy, psx, pcy;
  logic signed [SumW-1:0] sx, sy, shx, shy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_term      <= TrigW'(1 << TrigShift);
      sin_term      <= '0;
      image_width   <= SizeW'(MaxWidth);
      image_height  <= SizeW'(MaxHeight);
      channel_count <= ChanW'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COS:      cos_term      <= cfg_data[TrigW-1:0];
        CFG_SIN:      sin_term      <= cfg_data[TrigW-1:0];
        CFG_WIDTH:    image_width   <= cfg_data[SizeW-1:0];
        CFG_HEIGHT:   image_height  <= cfg_data[SizeW-1:0];
        CFG_CHANNELS: channel_count <= cfg_data[ChanW-1:0];
        default: ;
      endcase
    end
  end

  assign eff_w = (image_width > SizeW'(MaxWidth)) ? SizeW'(MaxWidth) : image_width;
  assign eff_h = (image_height > SizeW'(MaxHeight)) ? SizeW'(MaxHeight) : image_height;
  assign eff_c = (channel_count > ChanW'(MaxChannels)) ? ChanW'(MaxChannels) : channel_count;
  assign cxf   = {eff_w, (FracBits-1)'(0)};
  assign cyf   = {eff_h, (FracBits-1)'(0)};
  assign cfg   = '{width: eff_w, height: eff_h};

  assign en        = !s3v || !q_full;
  assign req.ready = en;
  assign push      = s3v && !q_full;
  assign push_item = s3;

  assign bad_in = (SizeW'(req.col) >= eff_w) || (SizeW'(req.row) >= eff_h) ||
                  (ChanW'(req.plane) >= eff_c);
  assign dx_in  = DeltaW'({req.col, FracBits'(0)}) - DeltaW'(cxf);
  assign dy_in  = DeltaW'({req.row, FracBits'(0)}) - DeltaW'(cyf);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
    end else if (en) begin
      s1v <= req.valid;
      s2v <= s1v;
      s3v <= s2v;
    end
  end

  assign sx  = SumW'(pcx) - SumW'(psy);
  assign sy  = SumW'(psx) + SumW'(pcy);
  assign shx = sx >>> TrigShift;
  assign shy = sy >>> TrigShift;

  always_ff @(posedge clk) begin
    if (en) begin
      s1.op    <= req.opcode;
      s1.bad   <= bad_in;
      s1.plane <= req.plane;
      s1.row   <= req.row;
      s1.col   <= req.col;
      s1.pixel <= req.pixel_in[PixelBits-1:0];
      s1.nx    <= '0;
      s1.ny    <= '0;
      s1_dx    <= dx_in;
      s1_dy    <= dy_in;

      s2  <= s1;
      pcx <= cos_term * s1_dx;
      psy <= sin_term * s1_dy;
      psx <= sin_term * s1_dx;
      pcy <= cos_term * s1_dy;

      s3.op    <= s2.op;
      s3.bad   <= s2.bad;
      s3.plane <= s2.plane;
      s3.row   <= s2.row;
      s3.col   <= s2.col;
      s3.pixel <= s2.pixel;
      s3.nx    <= shx[CoordW-1:0] + CoordW'(cxf);
      s3.ny    <= shy[CoordW-1:0] + CoordW'(cyf);
    end
  end

endmodule

@@ rtl/core/imr_queue.sv @@
// imr_queue: short word queue between front and back
// depends on imr_pkg
module imr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  imr_pkg::imr_item_t push_item,
  input  logic               pop,
  output imr_pkg::imr_item_t head,
  output logic               full,
  output logic               empty
);
  import imr_pkg::*;

  imr_item_t slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [QueuePtrW:0] count;

  assign full  = (count == (QueuePtrW+1)'(QueueDepth));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

@@ rtl/core/imr_back.sv @@
// imr_back: parity banked frame store, bilinear blend and output register
// depends on imr_pkg and imr_out_if
module imr_back (
  input  logic               clk,
  input  logic               rst,
  input  imr_pkg::imr_cfg_t  cfg,
  input  imr_pkg::imr_item_t head,
  input  logic               q_empty,
  output logic               pop,
  imr_out_if.source          rsp
);
  import imr_pkg::*;

  localparam int One = 1 << FracBits;

  logic en;
  logic signed [IntW-1:0] x0, y0, x1, y1, wi, hi;
  logic [FracBits-1:0] fx, fy;
  logic [FracBits:0] ax, bx, ay, by;
  logic vx0, vx1, vy0, vy1;
  logic wr_go;

  logic [PixelBits-1:0] bank_rd [4];
  logic [BankAddrW-1:0] bank_addr [4];
  logic bank_we [4];

  logic b1v, b1_bad, b1_out, b1_xp, b1_yp;
  logic [3:0] b1_ok;
  logic [WtW-1:0] w00, w01, w10, w11;
  logic [PixelBits-1:0] p00, p01, p10, p11;

  logic b2v, b2_bad, b2_out;
  logic [MulW-1:0] m00, m01, m10, m11;
  logic [AccW-1:0] acc;
  logic [AccW-1:0] rnd;
  logic [PixelBits-1:0] res;

  assign en  = !rsp.valid || rsp.ready;
  assign pop = en && !q_empty;

  assign x0 = head.nx[CoordW-1:FracBits];
  assign y0 = head.ny[CoordW-1:FracBits];
  assign x1 = x0 + 1'b1;
  assign y1 = y0 + 1'b1;
  assign fx = head.nx[FracBits-1:0];
  assign fy = head.ny[FracBits-1:0];
  assign bx = (FracBits+1)'(fx);
  assign by = (FracBits+1)'(fy);
  assign ax = (FracBits+1)'(One) - bx;
  assign ay = (FracBits+1)'(One) - by;
  assign wi = IntW'(cfg.width);
  assign hi = IntW'(cfg.height);
  assign vx0 = (x0 >= 0) && (x0 < wi);
  assign vx1 = (x1 >= 0) && (x1 < wi);
  assign vy0 = (y0 >= 0) && (y0 < hi);
  assign vy1 = (y1 >= 0) && (y1 < hi);
  assign wr_go = pop && (head.op == OP_WRITE) && !head.bad;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BankSel = 2'(b);
    logic [PixelBits-1:0] mem [BankDepth];
    logic [IntW-1:0] cpick, rpick;
    assign cpick = (x0[0] == BankSel[0]) ? x0 : x1;
    assign rpick = (y0[0] == BankSel[1]) ? y0 : y1;
    assign bank_we[b] = wr_go && (head.col[0] == BankSel[0]) &&
                        (head.row[0] == BankSel[1]);
    assign bank_addr[b] = (head.op == OP_WRITE) ?
        {head.plane, head.row[RowW-1:1], head.col[ColW-1:1]} :
        {head.plane, rpick[RowW-1:1], cpick[ColW-1:1]};

    always_ff @(posedge clk) begin
      if (pop) begin
        if (bank_we[b]) mem[bank_addr[b]] <= head.pixel;
        bank_rd[b] <= mem[bank_addr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1v       <= 1'b0;
      b2v       <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (en) begin
      b1v       <= pop;
      b2v       <= b1v;
      rsp.valid <= b2v && b2_out;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_bad <= head.bad;
      b1_out <= head.bad || (head.op == OP_READ);
      b1_xp  <= x0[0];
      b1_yp  <= y0[0];
      b1_ok  <= {vy1 && vx1, vy1 && vx0, vy0 && vx1, vy0 && vx0};
      w00    <= WtW'(ax) * WtW'(ay);
      w01    <= WtW'(bx) * WtW'(ay);
      w10    <= WtW'(ax) * WtW'(by);
      w11    <= WtW'(bx) * WtW'(by);
    end
  end

  assign p00 = b1_ok[0] ? bank_rd[{b1_yp, b1_xp}] : '0;
  assign p01 = b1_ok[1] ? bank_rd[{b1_yp, ~b1_xp}] : '0;
  assign p10 = b1_ok[2] ? bank_rd[{~b1_yp, b1_xp}] : '0;
  assign p11 = b1_ok[3] ? bank_rd[{~b1_yp, ~b1_xp}] : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      b2_bad <= b1_bad;
      b2_out <= b1_out;
      m00    <= MulW'(w00) * MulW'(p00);
      m01    <= MulW'(w01) * MulW'(p01);
      m10    <= MulW'(w10) * MulW'(p10);
      m11    <= MulW'(w11) * MulW'(p11);
    end
  end

  assign acc = AccW'(m00) + AccW'(m01) + AccW'(m10) + AccW'(m11);
  assign rnd = (acc + AccW'(1 << (2*FracBits - 1))) >> (2*FracBits);
  assign res = (rnd > AccW'((1 << PixelBits) - 1)) ? '1 : rnd[PixelBits-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.coord_error <= b2_bad;
      rsp.pixel_out   <= b2_bad ? '0 : res;
    end
  end

endmodule

@@ rtl/core/image_rotate_bilinear.sv @@
// image_rotate_bilinear: top level, rotation about the image center with
// bilinear sampling; depends on imr_pkg, imr_if, imr_front, imr_queue, imr_back
//
// pixel_req carries one word per item: opcode write stores pixel_in at
// (plane,row,col), opcode read asks for the rotated pixel at (col,row).
// pixel_rsp returns one word for each read and for each item whose
// coordinate lies outside the configured size (coord_error set, pixel 0);
// a good write returns nothing. Words leave in the order they came in.
// cfg_we/cfg_index/cfg_data write cos, sin, width, height and plane count
// while the block is idle.
// From the accepting edge an item passes the three front stages (range
// check, four 16x16 products, shift and center add), the queue, the frame
// store read, the blend products, and rounding into the output register.
// Throughput is one word per cycle while pixel_rsp is not stalled; the
// four frame store banks split by row and column parity give all four
// neighbors in one read.
// Reset restores the default registers and empties the pipeline; the
// frame store is not cleared. When pixel_rsp stalls, the back end holds,
// the four-entry queue fills, then pixel_req drops ready.
module image_rotate_bilinear (
  input  logic                        clk,
  input  logic                        rst,
  imr_in_if.sink                      pixel_req,
  imr_out_if.source                   pixel_rsp,
  input  logic                        cfg_we,
  input  logic [imr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [imr_pkg::CfgW-1:0]    cfg_data
);
  import imr_pkg::*;

  logic      q_full, q_empty, push, pop;
  imr_item_t push_item, head;
  imr_cfg_t  cfg;

  imr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (pixel_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  imr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  imr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .rsp     (pixel_rsp)
  );

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench of image_rotate_bilinear, rotation with bilinear sampling
// drives imr_in_if/imr_out_if and the config port; predicts every result in-bench
// depends on imr_pkg, imr_if and the rtl under rtl/core
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imr_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 24;

  typedef struct {
    logic [PixelBits-1:0] pixel;
    logic                 err;
  } rsp_word_t;

  typedef struct {
    op_t         op;
    logic [1:0]  plane;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] pix;
    bit          typed;
    logic [15:0] want_pix;
    logic        want_err;
  } stim_row_t;

  typedef struct {
    logic [15:0] cs;
    logic [15:0] sn;
    logic [6:0]  w;
    logic [6:0]  h;
    logic [2:0]  ch;
  } setting_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  imr_in_if  pixel_req();
  imr_out_if pixel_rsp();

  image_rotate_bilinear dut (
    .clk(clk), .rst(rst), .pixel_req(pixel_req), .pixel_rsp(pixel_rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // bench copy of block state
  logic [15:0] store_copy [0:MaxChannels*MaxHeight*MaxWidth-1];
  bit          written [0:MaxChannels*MaxHeight*MaxWidth-1];
  logic [15:0] m_cos, m_sin;
  logic [6:0]  m_w, m_h;
  logic [2:0]  m_ch;

  rsp_word_t pending[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int rsp_stall = 0;
  bit pressure_go = 0;
  bit pressure_done = 0;
  int hold_left = 0;

  initial begin
    pixel_req.valid = 0;
    pixel_req.opcode = OP_WRITE;
    pixel_req.plane = '0;
    pixel_req.row = '0;
    pixel_req.col = '0;
    pixel_req.pixel_in = '0;
    pixel_rsp.ready = 0;
  end

  function automatic longint clamp_size(longint v, longint mx);
    return (v > mx) ? mx : v;
  endfunction

  function automatic longint tap(longint p, longint yy, longint xx, longint w, longint h);
    if (xx < 0 || xx >= w || yy < 0 || yy >= h) return 0;
    return store_copy[(p * MaxHeight + yy) * MaxWidth + xx];
  endfunction

  // top-left source neighbor of output pixel (x,y)
  function automatic void src_corner(int y, int x, output longint x0, output longint y0);
    longint w, h, cs, sn, cxf, cyf, dx, dy, nx, ny;
    w = clamp_size(m_w, MaxWidth);
    h = clamp_size(m_h, MaxHeight);
    cs = longint'($signed(m_cos));
    sn = longint'($signed(m_sin));
    cxf = w * 128;
    cyf = h * 128;
    dx = x * 256 - cxf;
    dy = y * 256 - cyf;
    nx = ((cs * dx - sn * dy) >>> TrigShift) + cxf;
    ny = ((sn * dx + cs * dy) >>> TrigShift) + cyf;
    x0 = nx >>> FracBits;
    y0 = ny >>> FracBits;
  endfunction

  // expected rotated pixel, or an error word for a bad coordinate
  function automatic rsp_word_t rotate_sample(op_t op, int p, int y, int x, output bit no_rsp);
    rsp_word_t r;
    longint w, h, c, cs, sn, cxf, cyf, dx, dy, nx, ny, fx, fy, x0, y0, sum, res;
    w = clamp_size(m_w, MaxWidth);
    h = clamp_size(m_h, MaxHeight);
    c = clamp_size(m_ch, MaxChannels);
    no_rsp = 0;
    r.pixel = 0;
    r.err = 0;
    if (x >= w || y >= h || p >= c) begin
      r.err = 1;
      return r;
    end
    if (op == OP_WRITE) begin
      no_rsp = 1;
      return r;
    end
    cs = longint'($signed(m_cos));
    sn = longint'($signed(m_sin));
    cxf = w * 128;
    cyf = h * 128;
    dx = x * 256 - cxf;
    dy = y * 256 - cyf;
    nx = ((cs * dx - sn * dy) >>> TrigShift) + cxf;
    ny = ((sn * dx + cs * dy) >>> TrigShift) + cyf;
    fx = nx & 255;
    fy = ny & 255;
    x0 = nx >>> FracBits;
    y0 = ny >>> FracBits;
    sum = (256 - fx) * (256 - fy) * tap(p, y0, x0, w, h)
        + fx * (256 - fy) * tap(p, y0, x0 + 1, w, h)
        + (256 - fx) * fy * tap(p, y0 + 1, x0, w, h)
        + fx * fy * tap(p, y0 + 1, x0 + 1, w, h);
    res = (sum + 32768) >> 16;
    if (res > 65535) res = 65535;
    r.pixel = res[15:0];
    return r;
  endfunction

  task automatic send(op_t op, int p, int y, int x, logic [15:0] pix,
                      bit typed, logic [15:0] wp, logic we);
    rsp_word_t r;
    bit none;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      pixel_req.valid <= 0;
      @(negedge clk);
    end
    pixel_req.valid <= 1;
    pixel_req.opcode <= op;
    pixel_req.plane <= 2'(p);
    pixel_req.row <= 6'(y);
    pixel_req.col <= 6'(x);
    pixel_req.pixel_in <= pix;
    @(posedge clk);
    while (!pixel_req.ready) @(posedge clk);
    r = rotate_sample(op, p, y, x, none);
    if (!none && !r.err && op == OP_WRITE) none = 1;
    if (op == OP_WRITE && !r.err) begin
      store_copy[(p * MaxHeight + y) * MaxWidth + x] = pix;
      written[(p * MaxHeight + y) * MaxWidth + x] = 1;
    end
    if (typed) begin
      r.pixel = wp;
      r.err = we;
    end
    if (!none) pending.push_back(r);
  endtask

  // writes any in-range neighbor of a read that was never written
  task automatic prime(int p, int y, int x, inout int cnt);
    longint w, h, c, x0, y0, xx, yy;
    w = clamp_size(m_w, MaxWidth);
    h = clamp_size(m_h, MaxHeight);
    c = clamp_size(m_ch, MaxChannels);
    if (x >= w || y >= h || p >= c) return;
    src_corner(y, x, x0, y0);
    for (int j = 0; j < 4; j++) begin
      yy = y0 + j / 2;
      xx = x0 + j % 2;
      if (xx >= 0 && xx < w && yy >= 0 && yy < h &&
          !written[(p * MaxHeight + yy) * MaxWidth + xx]) begin
        send(OP_WRITE, p, int'(yy), int'(xx), 16'($urandom), 0, 0, 0);
        cnt++;
      end
    end
  endtask

  task automatic go_idle();
    @(negedge clk);
    pixel_req.valid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] d);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      CFG_COS: m_cos = d;
      CFG_SIN: m_sin = d;
      CFG_WIDTH: m_w = d[6:0];
      CFG_HEIGHT: m_h = d[6:0];
      CFG_CHANNELS: m_ch = d[2:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(CFG_COS, s.cs);
    write_reg(CFG_SIN, s.sn);
    write_reg(CFG_WIDTH, {9'd0, s.w});
    write_reg(CFG_HEIGHT, {9'd0, s.h});
    write_reg(CFG_CHANNELS, {13'd0, s.ch});
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // receiver
  always @(negedge clk) begin
    if (pressure_go && !pressure_done) begin
      hold_left = 400;
      pressure_done = 1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pixel_rsp.ready <= 0;
    end else begin
      pixel_rsp.ready <= ($urandom_range(99) >= rsp_stall);
    end
  end

  // result checker
  always @(posedge clk) begin
    rsp_word_t e;
    if (!rst && pixel_rsp.valid && pixel_rsp.ready) begin
      if (pending.size() == 0) begin
        $error("unexpected word: pixel_out %0h coord_error %0b",
               pixel_rsp.pixel_out, pixel_rsp.coord_error);
        errors++;
      end else begin
        e = pending.pop_front();
        if (pixel_rsp.pixel_out !== e.pixel) begin
          $error("pixel_out expected %0h actual %0h", e.pixel, pixel_rsp.pixel_out);
          errors++;
        end
        if (pixel_rsp.coord_error !== e.err) begin
          $error("coord_error expected %0b actual %0b", e.err, pixel_rsp.coord_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t early[$];
    stim_row_t directed[$];
    setting_t plan[$];
    setting_t s;
    int modes[4];
    int n, p, y, x;
    int sent;
    int extra;
    op_t op;
    m_cos = 16'd16384;
    m_sin = 0;
    m_w = 7'd64;
    m_h = 7'd64;
    m_ch = 3'd1;
    extra = 0;
    modes = '{0, 1, 2, 3};
    // reset config: only plane 0 in range
    early.push_back('{OP_WRITE, 2'd3, 6'd0, 6'd0, 16'hffff, 1, 16'h0, 1'b1});
    early.push_back('{OP_READ,  2'd1, 6'd63, 6'd63, 16'h0, 1, 16'h0, 1'b1});
    early.push_back('{OP_READ,  2'd2, 6'd0, 6'd63, 16'h1234, 1, 16'h0, 1'b1});
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (early[i])
      send(early[i].op, early[i].plane, early[i].row, early[i].col, early[i].pix,
           1, early[i].want_pix, early[i].want_err);
    go_idle();
    // unknown indexes are ignored
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= 3'd5;
    cfg_data <= 16'hffff;
    @(negedge clk);
    cfg_index <= 3'd6;
    @(negedge clk);
    cfg_index <= 3'd7;
    cfg_data <= 16'h0;
    @(negedge clk);
    cfg_we <= 0;
    s = '{16'd16384, 16'd0, 7'd64, 7'd64, 3'd4};
    apply_setting(s);
    // identity rotation returns the stored pixel
    directed.push_back('{OP_WRITE, 2'd0, 6'd0, 6'd0, 16'hffff, 0, 16'h0, 1'b0});
    directed.push_back('{OP_READ,  2'd0, 6'd0, 6'd0, 16'h0, 1, 16'hffff, 1'b0});
    directed.push_back('{OP_WRITE, 2'd3, 6'd63, 6'd63, 16'h0000, 0, 16'h0, 1'b0});
    directed.push_back('{OP_READ,  2'd3, 6'd63, 6'd63, 16'hffff, 1, 16'h0000, 1'b0});
    directed.push_back('{OP_WRITE, 2'd2, 6'd31, 6'd32, 16'h5a5a, 0, 16'h0, 1'b0});
    directed.push_back('{OP_READ,  2'd2, 6'd31, 6'd32, 16'h0, 1, 16'h5a5a, 1'b0});
    directed.push_back('{OP_READ,  2'd1, 6'd0, 6'd63, 16'h0, 0, 16'h0, 1'b0});
    directed.push_back('{OP_READ,  2'd1, 6'd63, 6'd0, 16'h0, 0, 16'h0, 1'b0});
    foreach (directed[i]) begin
      if (directed[i].op == OP_READ)
        prime(int'(directed[i].plane), int'(directed[i].row), int'(directed[i].col),
              extra);
      send(directed[i].op, directed[i].plane, directed[i].row, directed[i].col,
           directed[i].pix, directed[i].typed, directed[i].want_pix,
           directed[i].want_err);
    end
    go_idle();
    plan.push_back('{16'd16384, 16'd0, 7'd64, 7'd64, 3'd4});
    plan.push_back('{-16'sd16384, 16'd0, 7'd64, 7'd64, 3'd4});
    plan.push_back('{16'd0, 16'd16384, 7'd64, 7'd64, 3'd4});
    plan.push_back('{16'd0, -16'sd16384, 7'd63, 7'd64, 3'd4});
    plan.push_back('{16'd11585, 16'd11585, 7'd37, 7'd50, 3'd3});
    plan.push_back('{-16'sd16384, 16'd16384, 7'd1, 7'd1, 3'd1});
    plan.push_back('{16'd0, 16'd0, 7'd0, 7'd64, 3'd4});
    plan.push_back('{16'h8000, 16'h7fff, 7'd127, 7'd127, 3'd7});
    plan.push_back('{16'd14189, -16'sd8192, 7'd2, 7'd64, 3'd0});
    plan.push_back('{16'd15137, 16'd6270, 7'd64, 7'd2, 3'd2});
    foreach (plan[k]) begin
      apply_setting(plan[k]);
      send_idle = (modes[k % 4] == 1 || modes[k % 4] == 3) ? 68 : 0;
      rsp_stall = (modes[k % 4] == 2 || modes[k % 4] == 3) ? 68 : 0;
      if (modes[k % 4] == 3) begin
        send_idle = 7;
        rsp_stall = 7;
      end
      if (k == 1) pressure_go = 1;
      n = 140;
      sent = 0;
      while (sent < n) begin
        op = ($urandom_range(99) < 70) ? OP_READ : OP_WRITE;
        p = $urandom_range(3);
        y = $urandom_range(63);
        x = $urandom_range(63);
        if (op == OP_READ) prime(p, y, x, sent);
        send(op, p, y, x, 16'($urandom), 0, 0, 0);
        sent++;
      end
      go_idle();
    end
    if (errors == 0 && pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
